>>> src/mwg_pkg.sv
// Shared constants, types and the quarter-wave table builder of the waveform generator.
// No dependencies; every other file of the block but mwg_in_if uses this package.
`timescale 1ns / 1ps

package mwg_pkg;

  // datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int TAB_N    = 1 << TABLE_ADDR_BITS;
  localparam int SAT_LIM  = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int RAMP_W   = 18;  // signed ramp and product operand
  localparam int VAL_W    = 18;  // signed sample before saturation
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_WORD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH   = 3'd4;

  // waveform codes
  localparam logic [2:0] MODE_SINE     = 3'd0;
  localparam logic [2:0] MODE_COSINE   = 3'd1;
  localparam logic [2:0] MODE_SQUARE   = 3'd2;
  localparam logic [2:0] MODE_SAWTOOTH = 3'd3;
  localparam logic [2:0] MODE_TRIANGLE = 3'd4;

  // register reset values
  localparam logic [2:0]  RST_WAVE_MODE    = MODE_SINE;
  localparam logic [14:0] RST_AMPLITUDE    = 15'd16384;
  localparam logic [30:0] RST_FREQ_WORD    = 31'd42949673;
  localparam logic [31:0] RST_PHASE_OFFSET = 32'd0;
  localparam logic [15:0] RST_SEQ_LENGTH   = 16'd1024;

  typedef struct packed {
    logic [2:0]  wave_mode;
    logic [14:0] amplitude;
    logic [30:0] freq_word;
    logic [31:0] phase_offset;
    logic [15:0] seq_length;
  } cfg_t;

  // first pipeline stage contents
  typedef struct packed {
    logic                     neg;     // sine quadrant in lower half
    logic                     sq_pos;  // square wave high
    logic signed [RAMP_W-1:0] ramp;    // sawtooth or triangle factor
    logic                     last;
  } stage_t;

  typedef logic [15:0] qtab_t [TAB_N];

  // cycle fraction times 2^32 aligned to the phase width
  function automatic logic [PHASE_BITS-1:0] align_word(input logic [31:0] w);
    logic [PHASE_BITS+31:0] ext;
    ext = {w, {PHASE_BITS{1'b0}}};
    return ext[PHASE_BITS+31:32];
  endfunction

  // quarter-wave sine at half-step points, Q16, from a Q30 Taylor series
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] q;
    longint      s;
    int          k;
    int          n;
    for (k = 0; k < TAB_N; k++) begin
      x = (PI_HALF_Q30 * 64'(2 * k + 1)) / 64'(2 * TAB_N);
      t = x;
      s = longint'(x);
      for (n = 1; n <= 6; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      q = (64'(s) + 64'd8192) >> 14;
      if (q > 64'd65535) begin
        q = 64'd65535;
      end
      tab[k] = q[15:0];
    end
    return tab;
  endfunction

endpackage

>>> src/mwg_in_if.sv
// Input channel of the waveform generator: one restart flag per beat.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps

interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> src/mwg_out_if.sv
// Output channel of the waveform generator: one signed sample and a last flag per beat.
// Depends on mwg_pkg for the sample width.
`timescale 1ns / 1ps

interface mwg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample;
  logic                                  last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

>>> src/mwg_cfg.sv
// Configuration register file of the waveform generator.
// Depends on mwg_pkg for register indexes, reset values and the cfg_t bundle.
`timescale 1ns / 1ps

module mwg_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mwg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mwg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output mwg_pkg::cfg_t                      cfg_o
);

  mwg_pkg::cfg_t cfg_q;
  mwg_pkg::cfg_t cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwg_pkg::REG_WAVE_MODE:    cfg_d.wave_mode    = cfg_data_i[2:0];
        mwg_pkg::REG_AMPLITUDE:    cfg_d.amplitude    = cfg_data_i[14:0];
        mwg_pkg::REG_FREQ_WORD:    cfg_d.freq_word    = cfg_data_i[30:0];
        mwg_pkg::REG_PHASE_OFFSET: cfg_d.phase_offset = cfg_data_i[31:0];
        mwg_pkg::REG_SEQ_LENGTH:   cfg_d.seq_length   = cfg_data_i[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_mode    <= mwg_pkg::RST_WAVE_MODE;
      cfg_q.amplitude    <= mwg_pkg::RST_AMPLITUDE;
      cfg_q.freq_word    <= mwg_pkg::RST_FREQ_WORD;
      cfg_q.phase_offset <= mwg_pkg::RST_PHASE_OFFSET;
      cfg_q.seq_length   <= mwg_pkg::RST_SEQ_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/mwg_qrom.sv
// Quarter-wave sine table with registered read data.
// Depends on mwg_pkg for the table size and the table builder.
`timescale 1ns / 1ps

module mwg_qrom (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [mwg_pkg::TABLE_ADDR_BITS-1:0]  addr_i,
  output logic [15:0]                          data_o
);

  localparam mwg_pkg::qtab_t QTAB = mwg_pkg::build_qtab();

  logic [15:0] data_q;

  // synchronous table read, held while the stage stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= QTAB[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

>>> src/mwg_phase.sv
// Phase accumulator, sample counter and first pipeline stage of the generator.
// Depends on mwg_pkg for widths, waveform codes and the stage_t bundle.
`timescale 1ns / 1ps

module mwg_phase (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 restart_i,
  input  mwg_pkg::cfg_t                        cfg_i,
  output logic [mwg_pkg::TABLE_ADDR_BITS-1:0]  rom_addr_o,
  output mwg_pkg::stage_t                      stage_o
);

  localparam int PB = mwg_pkg::PHASE_BITS;
  localparam int TA = mwg_pkg::TABLE_ADDR_BITS;
  localparam logic [PB-1:0] HALF    = {1'b1, {(PB - 1){1'b0}}};
  localparam logic [PB-1:0] QUARTER = {2'b01, {(PB - 2){1'b0}}};

  logic [PB-1:0]   phase_acc_q;
  logic [PB-1:0]   phase_acc_d;
  logic [15:0]     index_q;
  logic [15:0]     index_d;
  logic [PB-1:0]   ph_cur;
  logic [15:0]     idx_cur;
  logic            last;
  logic [PB-1:0]   sine_ph;
  logic [TA+1:0]   top;
  logic [15:0]     f16;
  logic [18:0]     fx2;
  logic [18:0]     fx4;
  logic [18:0]     ramp_w;
  mwg_pkg::stage_t stage_d;
  mwg_pkg::stage_t stage_q;

  // restart takes effect before this beat's sample
  assign ph_cur  = restart_i ? '0 : phase_acc_q;
  assign idx_cur = restart_i ? '0 : index_q;
  assign last    = (idx_cur == (cfg_i.seq_length - 16'd1));

  // next phase and index, both wrap to zero after the last sample
  always_comb begin
    if (last) begin
      phase_acc_d = '0;
      index_d     = '0;
    end else begin
      phase_acc_d = ph_cur + mwg_pkg::align_word({1'b0, cfg_i.freq_word});
      index_d     = idx_cur + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      index_q     <= '0;
    end else if (accept_i) begin
      phase_acc_q <= phase_acc_d;
      index_q     <= index_d;
    end
  end

  // sine table address with offset, cosine adds a quarter cycle
  assign sine_ph = ph_cur + mwg_pkg::align_word(cfg_i.phase_offset)
                   + ((cfg_i.wave_mode == mwg_pkg::MODE_COSINE) ? QUARTER : '0);
  assign top        = sine_ph[PB-1 -: TA+2];
  assign rom_addr_o = top[TA] ? ~top[TA-1:0] : top[TA-1:0];

  // ramp factors for sawtooth and triangle
  assign f16 = ph_cur[PB-1 -: 16];
  assign fx2 = {2'b00, f16, 1'b0};
  assign fx4 = {1'b0, f16, 2'b00};

  always_comb begin
    case (cfg_i.wave_mode)
      mwg_pkg::MODE_SAWTOOTH: ramp_w = fx2 - 19'd65536;
      default: begin
        if (!f16[15]) begin
          ramp_w = fx4 - 19'd65536;
        end else begin
          ramp_w = 19'd196608 - fx4;
        end
      end
    endcase
  end

  always_comb begin
    stage_d.neg    = top[TA+1];
    stage_d.sq_pos = (ph_cur <= HALF);
    stage_d.ramp   = $signed(ramp_w[mwg_pkg::RAMP_W-1:0]);
    stage_d.last   = last;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

>>> src/mwg_shape.sv
// Second pipeline stage: amplitude scaling, waveform select and saturation.
// Depends on mwg_pkg for widths, waveform codes and the stage_t bundle.
`timescale 1ns / 1ps

module mwg_shape (
  input  logic                                   clk_i,
  input  logic                                   load_i,
  input  mwg_pkg::stage_t                        stage_i,
  input  logic [15:0]                            tab_i,
  input  logic [2:0]                             wave_mode_i,
  input  logic [14:0]                            amplitude_i,
  output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic                                   last_o
);

  localparam int VW = mwg_pkg::VAL_W;
  localparam int RW = mwg_pkg::RAMP_W;

  logic signed [RW-1:0]   mul_b;
  logic signed [RW+15:0]  prod;
  logic signed [RW+15:0]  prod_rnd;
  logic signed [VW-1:0]   scaled;
  logic signed [VW-1:0]   amp_s;
  logic signed [VW-1:0]   val;
  logic signed [31:0]     val_ext;
  logic signed [31:0]     val_sat;
  logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                   last_q;

  // one shared multiplier: table value for sine and cosine, ramp factor otherwise
  assign mul_b = ((wave_mode_i == mwg_pkg::MODE_SINE) ||
                  (wave_mode_i == mwg_pkg::MODE_COSINE))
                 ? $signed({{(RW - 16){1'b0}}, tab_i}) : stage_i.ramp;
  assign prod     = (RW + 16)'($signed({1'b0, amplitude_i})) * (RW + 16)'(mul_b);
  assign prod_rnd = prod + (RW + 16)'(32768);
  assign scaled   = prod_rnd[RW+15:16];
  assign amp_s    = $signed({{(VW - 15){1'b0}}, amplitude_i});

  // waveform select
  always_comb begin
    case (wave_mode_i)
      mwg_pkg::MODE_SINE, mwg_pkg::MODE_COSINE: val = stage_i.neg ? -scaled : scaled;
      mwg_pkg::MODE_SQUARE:                     val = stage_i.sq_pos ? amp_s : -amp_s;
      mwg_pkg::MODE_SAWTOOTH,
      mwg_pkg::MODE_TRIANGLE:                   val = scaled;
      default:                                  val = '0;
    endcase
  end

  // symmetric saturation to the sample width
  assign val_ext = 32'(val);
  always_comb begin
    if (val_ext > 32'(mwg_pkg::SAT_LIM)) begin
      val_sat = 32'(mwg_pkg::SAT_LIM);
    end else if (val_ext < -32'(mwg_pkg::SAT_LIM)) begin
      val_sat = -32'(mwg_pkg::SAT_LIM);
    end else begin
      val_sat = val_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= val_sat[mwg_pkg::SAMPLE_BITS-1:0];
      last_q   <= stage_i.last;
    end
  end

  assign sample_o = sample_q;
  assign last_o   = last_q;

endmodule

>>> src/multi_waveform_generator.sv
// Top level of the waveform generator: configuration, phase stage, table and output stage.
// Depends on mwg_pkg, mwg_in_if, mwg_out_if, mwg_cfg, mwg_phase, mwg_qrom and mwg_shape.
`timescale 1ns / 1ps

// Direct digital synthesis source: every input beat (a restart flag) yields one signed
// sample of the selected waveform (sine, cosine, square, sawtooth, triangle) plus a flag
// on the last sample of each sequence. One beat is taken every clock unless the output
// holds the pipeline off; each beat passes the phase stage and quarter-wave table read,
// then the amplitude multiply and saturation. Back-pressure on the output stalls both
// stages; the input stays ready while either stage has room. Reset clears the phase and
// sample index and loads the register defaults. The user must write registers through the
// plain write port only while no beat is in flight; the block itself does not enforce it.
module multi_waveform_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mwg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mwg_in_if.sink                            in_i,
  mwg_out_if.source                         out_o
);

  mwg_pkg::cfg_t   cfg;
  mwg_pkg::stage_t stage;
  logic [mwg_pkg::TABLE_ADDR_BITS-1:0] rom_addr;
  logic [15:0]     tab;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            out_load;
  logic            s1_en;
  logic            accept;

  // pipeline flow control
  assign out_load = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_en    = !s1_valid_q || out_load;
  assign accept   = in_i.valid && s1_en;
  assign in_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= accept;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  mwg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mwg_phase u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .restart_i  (in_i.restart),
    .cfg_i      (cfg),
    .rom_addr_o (rom_addr),
    .stage_o    (stage)
  );

  mwg_qrom u_qrom (
    .clk_i  (clk_i),
    .en_i   (accept),
    .addr_i (rom_addr),
    .data_o (tab)
  );

  mwg_shape u_shape (
    .clk_i       (clk_i),
    .load_i      (out_load),
    .stage_i     (stage),
    .tab_i       (tab),
    .wave_mode_i (cfg.wave_mode),
    .amplitude_i (cfg.amplitude),
    .sample_o    (out_o.sample),
    .last_o      (out_o.last)
  );

  assign out_o.valid = out_valid_q;

endmodule

>>> verif/tb_multi_waveform_generator.sv
// Testbench for multi_waveform_generator: drives restart beats, predicts each sample and
// its last flag, and checks them in order. Depends on mwg_pkg, mwg_in_if and mwg_out_if.
`timescale 1ns / 1ps

module tb_multi_waveform_generator;
  import mwg_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 7;
  localparam int IDLE_MAX      = 18;
  localparam int STALL_CYCLES  = 120;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int MAX_REPORTS   = 40;
  localparam int WRAP_START    = 40;
  localparam int SHORT_LEN     = 5;
  localparam longint TIMEOUT_NS = 10_000_000;

  localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_BITS-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [2:0]            MODE_TOP     = 3'h7;  // highest unassigned mode code
  localparam longint                Q16_ONE      = 65536;
  localparam longint                Q16_HALF     = 32768;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smp;
    logic                   last;
  } sample_beat_t;

  // waveform predictor and in-order sample checker
  class waveform_scoreboard;
    cfg_t                 regs;
    logic [PHASE_BITS-1:0] phase_acc;
    logic [15:0]          sample_idx;
    longint unsigned      quarter_sine [TAB_N];
    sample_beat_t         expected_q [$];
    int                   errors;
    int                   checked;
    int                   seq_ends;

    function new();
      regs = cfg_t'{RST_WAVE_MODE, RST_AMPLITUDE, RST_FREQ_WORD, RST_PHASE_OFFSET,
                    RST_SEQ_LENGTH};
      phase_acc  = '0;
      sample_idx = '0;
      errors     = 0;
      checked    = 0;
      seq_ends   = 0;
      build_quarter_sine();
    endfunction

    // half-step quarter sine in Q16, Taylor series in Q30 with truncated terms
    function void build_quarter_sine();
      longint unsigned x;
      longint unsigned t;
      longint unsigned q;
      longint          s;
      for (int k = 0; k < TAB_N; k++) begin
        x = (longint'(PI_HALF_Q30) * longint'(2 * k + 1)) / longint'(2 * TAB_N);
        t = x;
        s = longint'(x);
        for (int n = 1; n <= 6; n++) begin
          t = (t * x) >> 30;
          t = (t * x) >> 30;
          t = t / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            s = s - longint'(t);
          end else begin
            s = s + longint'(t);
          end
        end
        if (s < 0) begin
          s = 0;
        end
        q = (longint'(s) + 8192) >> 14;
        if (q > 65535) begin
          q = 65535;
        end
        quarter_sine[k] = q;
      end
    endfunction

    function longint round_q16(longint n);
      return (n + Q16_HALF) >>> 16;
    endfunction

    function longint sine_value(logic [PHASE_BITS-1:0] p);
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] idx;
      longint unsigned            tv;
      longint unsigned            mag;
      quad = p[PHASE_BITS-1 -: 2];
      idx  = p[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      tv   = quad[0] ? quarter_sine[TAB_N - 1 - int'(idx)] : quarter_sine[idx];
      mag  = (longint'(regs.amplitude) * tv + 32768) >> 16;
      return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // advance the generator by one accepted beat and queue its sample
    function void note_beat(logic restart);
      logic [PHASE_BITS-1:0] ph;
      logic [15:0]           final_idx;
      longint                f16;
      longint                amp;
      longint                v;
      sample_beat_t          e;
      if (restart) begin
        phase_acc  = '0;
        sample_idx = '0;
      end
      ph  = phase_acc;
      f16 = longint'(ph[PHASE_BITS-1 -: 16]);
      amp = longint'(regs.amplitude);
      case (regs.wave_mode)
        MODE_SINE:     v = sine_value(ph + regs.phase_offset);
        MODE_COSINE:   v = sine_value(ph + regs.phase_offset + QUARTER_TURN);
        MODE_SQUARE:   v = (ph <= HALF_TURN) ? amp : -amp;
        MODE_SAWTOOTH: v = round_q16(amp * (2 * f16 - Q16_ONE));
        MODE_TRIANGLE: begin
          if (f16 < Q16_HALF) begin
            v = round_q16(amp * (4 * f16 - Q16_ONE));
          end else begin
            v = round_q16(amp * (3 * Q16_ONE - 4 * f16));
          end
        end
        default:       v = 0;
      endcase
      if (v > SAT_LIM) begin
        v = SAT_LIM;
      end
      if (v < -SAT_LIM) begin
        v = -SAT_LIM;
      end
      // zero length wraps to the full 16-bit range here
      final_idx = regs.seq_length - 16'd1;
      e.last    = (sample_idx == final_idx);
      e.smp     = v[SAMPLE_BITS-1:0];
      expected_q.push_back(e);
      if (e.last) begin
        phase_acc  = '0;
        sample_idx = '0;
      end else begin
        phase_acc  = ph + PHASE_BITS'(regs.freq_word);
        sample_idx = sample_idx + 16'd1;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) begin
        $display("mismatch at %0t ns: %s", $time, msg);
      end
      errors++;
    endtask

    task check_beat(logic [SAMPLE_BITS-1:0] smp, logic last);
      sample_beat_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("sample %0d with nothing expected", $signed(smp)));
      end else begin
        e = expected_q.pop_front();
        if (smp !== e.smp) begin
          report_mismatch($sformatf("sample %0d, expected %0d (beat %0d)",
                                    $signed(smp), $signed(e.smp), checked));
        end
        if (last !== e.last) begin
          report_mismatch($sformatf("last %b, expected %b (beat %0d)",
                                    last, e.last, checked));
        end
      end
      checked++;
      if (last === 1'b1) begin
        seq_ends++;
      end
    endtask
  endclass

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mwg_in_if  in_ch ();
  mwg_out_if out_ch ();

  multi_waveform_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  waveform_scoreboard sb;
  int gap_limit      = 0;
  bit stall_req      = 1'b0;
  int settings_used  = 0;
  int restarts_sent  = 0;
  int items_sent     = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // wait until every queued sample has come out, then let the pipeline settle
  task automatic wait_idle();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all five registers on consecutive edges while idle
  task automatic apply_settings(cfg_t c);
    logic [CFG_IDX_W-1:0] r;
    logic [CFG_DATA_W-1:0] d;
    wait_idle();
    for (int i = REG_WAVE_MODE; i <= REG_SEQ_LENGTH; i++) begin
      r = CFG_IDX_W'(i);
      case (r)
        REG_WAVE_MODE:    d = CFG_DATA_W'(c.wave_mode);
        REG_AMPLITUDE:    d = CFG_DATA_W'(c.amplitude);
        REG_FREQ_WORD:    d = CFG_DATA_W'(c.freq_word);
        REG_PHASE_OFFSET: d = CFG_DATA_W'(c.phase_offset);
        default:          d = CFG_DATA_W'(c.seq_length);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= d;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.regs = c;
    settings_used++;
  endtask

  // offer one restart beat after a random gap and hold it until taken
  task automatic send_beat(logic restart_bit);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart_bit;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk_i);
    end
    sb.note_beat(restart_bit);
    items_sent++;
    if (restart_bit) begin
      restarts_sent++;
    end
  endtask

  task automatic run_items(int n, bit first_restart, int restart_pct);
    logic r;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        r = first_restart;
      end else begin
        r = ($urandom_range(0, 99) < restart_pct);
      end
      send_beat(r);
    end
    in_ch.valid <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    if ($urandom_range(0, 7) == 0) begin
      c.wave_mode = 3'($urandom_range(MODE_TRIANGLE + 1, MODE_TOP));
    end else begin
      c.wave_mode = 3'($urandom_range(MODE_SINE, MODE_TRIANGLE));
    end
    case ($urandom_range(0, 9))
      0:       c.amplitude = '0;
      1:       c.amplitude = '1;
      default: c.amplitude = 15'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       c.freq_word = '0;
      1:       c.freq_word = 31'd1;
      2:       c.freq_word = '1;
      3, 4, 5: c.freq_word = 31'($urandom_range(1, 1 << 22));
      default: c.freq_word = 31'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0:       c.phase_offset = '0;
      1:       c.phase_offset = '1;
      default: c.phase_offset = $urandom();
    endcase
    // mostly short sequences so that sequence ends come often
    case ($urandom_range(0, 9))
      0:       c.seq_length = 16'd1;
      1:       c.seq_length = 16'($urandom());
      default: c.seq_length = 16'($urandom_range(1, 48));
    endcase
    return c;
  endfunction

  // output side: random ready gaps plus one long hold-off
  initial begin : sample_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        for (int held = 0; held < STALL_CYCLES; held++) begin
          @(posedge clk_i);
        end
        stall_req = 1'b0;
      end
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (out_ch.valid !== 1'b1) begin
        @(posedge clk_i);
      end
      sb.check_beat(out_ch.sample, out_ch.last);
    end
  end

  // stimulus
  initial begin : stimulus
    cfg_t c;
    int   random_sent;
    int   n;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_WAVE_MODE;
    cfg_data_i    <= '0;
    sb = new();
    random_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: register defaults straight out of reset
    gap_limit = IDLE_MAX;
    run_items(3, 1'b0, 0);
    // length one, largest step and offset
    apply_settings(cfg_t'{MODE_SINE, 15'h7FFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd1});
    run_items(3, 1'b1, 0);
    // zero amplitude, frozen phase, longest explicit length
    apply_settings(cfg_t'{MODE_COSINE, 15'h0000, 31'd0, 32'h0, 16'hFFFF});
    run_items(2, 1'b0, 0);
    apply_settings(cfg_t'{MODE_COSINE, 15'h7FFF, 31'h0100_0000, 32'h2000_0000, 16'd3});
    run_items(2, 1'b1, 0);
    // quarter steps land exactly on the half-cycle edge of the square
    apply_settings(cfg_t'{MODE_SQUARE, 15'h7FFF, 31'h4000_0000, 32'h0, 16'd4});
    run_items(4, 1'b1, 0);
    apply_settings(cfg_t'{MODE_SAWTOOTH, 15'h7FFF, 31'h2000_0000, 32'h0, 16'd8});
    run_items(3, 1'b1, 0);
    apply_settings(cfg_t'{MODE_TRIANGLE, 15'h7FFF, 31'h2000_0000, 32'h0, 16'd8});
    run_items(4, 1'b1, 0);
    // unassigned mode gives silence while the phase runs on
    apply_settings(cfg_t'{MODE_TOP, 15'h1234, 31'd1000, 32'h0, 16'd2});
    run_items(2, 1'b0, 0);

    // zero length never ends early, then a shortened length leaves the index past the end
    gap_limit = 0;
    c = cfg_t'{MODE_SAWTOOTH, 15'h7FFF, 31'd65537, 32'h0, 16'd0};
    apply_settings(c);
    run_items(WRAP_START, 1'b1, 0);
    c.seq_length = 16'(SHORT_LEN);
    apply_settings(c);
    run_items(WRAP_START, 1'b0, 0);

    // long output hold-off while beats keep coming
    apply_settings(cfg_t'{MODE_SINE, 15'h5A5A, 31'h0123_4567, 32'h1111_0000, 16'd17});
    stall_req = 1'b1;
    run_items(60, 1'b1, 3);

    // random settings with runs of restart beats
    while (random_sent < RANDOM_ITEMS) begin
      apply_settings(random_settings());
      gap_limit = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      n = $urandom_range(8, 60);
      run_items(n, 1'($urandom_range(0, 1)), 6);
      random_sent += n;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d samples, %0d sequence ends, %0d restarts, %0d register settings",
             sb.checked, sb.seq_ends, restarts_sent, settings_used);
    $display("included a zero-length sequence, an index past a shortened length and a %0d-cycle output hold-off",
             STALL_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multi_waveform_generator test passed");
    end else begin
      $display("multi_waveform_generator test failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d samples outstanding", sb.pending());
    $display("multi_waveform_generator test failed");
    $finish;
  end

endmodule
